// ===== sv/amd_pkg.sv =====
package amd_pkg;

  localparam int unsigned CfgIdxW = 3;

  typedef logic [CfgIdxW-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_DEADBAND_XY = 3'd0;
  localparam cfg_idx_t REG_DEADBAND_Z  = 3'd1;
  localparam cfg_idx_t REG_CONFIRM_MS  = 3'd2;
  localparam cfg_idx_t REG_SETTLE_MS   = 3'd3;
  localparam cfg_idx_t REG_REBASE_MS   = 3'd4;

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_ACK    = 1'b1;

  localparam logic [15:0] DEADBAND_XY_RST = 16'd1000;
  localparam logic [15:0] DEADBAND_Z_RST  = 16'd1500;
  localparam logic [31:0] CONFIRM_MS_RST  = 32'd3000;
  localparam logic [31:0] SETTLE_MS_RST   = 32'd2000;
  localparam logic [31:0] REBASE_MS_RST   = 32'd10000;

  typedef struct packed {
    logic               cmd;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic        [31:0] time_ms;
  } in_t;

  typedef struct packed {
    logic recalib_event;
    logic alert;
    logic moving;
    logic baseline_ready;
  } out_t;

  typedef struct packed {
    logic [15:0] deadband_xy;
    logic [15:0] deadband_z;
    logic [31:0] confirm_ms;
    logic [31:0] settle_ms;
    logic [31:0] rebase_ms;
  } cfg_t;

  typedef struct packed {
    logic signed [15:0] base_x;
    logic signed [15:0] base_y;
    logic signed [15:0] base_z;
    logic               base_valid;
    logic        [31:0] rebase_stamp;
    logic        [31:0] motion_since;
    logic               alert_latched;
  } state_t;

endpackage

// ===== sv/accel_motion_detector.sv =====
// Accelerometer motion detector.
// Input channel (in_valid/in_ready/in_data): one beat per accelerometer
// sample with its millisecond timestamp, or an acknowledge that clears the
// alert (cmd = 1). Result channel (out_valid/out_ready/out_data): exactly one
// beat per input beat, in order, carrying the event, alert, moving and
// baseline flags after that item.
// Configuration channel (cfg_valid/cfg_ready/cfg_index/cfg_data): always
// ready; writes deadbands and time windows. The user must write only while
// the block is idle; the block does not enforce it. The result passes an
// input register, then one pass of subtract/abs/compare logic into the
// result register, which also updates the baseline and motion timer.
// Throughput is one beat per cycle while out_ready is high; on a stall the
// result register holds, and in_ready drops once the input register is full.
// Reset clears the pipeline, the baseline, the motion timer and the alert,
// and restores the configuration defaults.
module accel_motion_detector (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  amd_pkg::in_t              in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output amd_pkg::out_t             out_data,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [amd_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [31:0]               cfg_data
);
  import amd_pkg::*;

  cfg_t   cfg_r;
  state_t st_r, st_nxt;
  in_t    item_r;
  logic   item_vld_r;
  out_t   res_r, res_nxt;
  logic   res_vld_r;
  logic   advance;

  assign cfg_ready = 1'b1;
  assign advance   = item_vld_r && (!res_vld_r || out_ready);
  assign in_ready  = !item_vld_r || advance;
  assign out_valid = res_vld_r;
  assign out_data  = res_r;

  amd_step u_step (
    .item   (item_r),
    .cfg    (cfg_r),
    .st     (st_r),
    .st_nxt (st_nxt),
    .res    (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.deadband_xy <= DEADBAND_XY_RST;
      cfg_r.deadband_z  <= DEADBAND_Z_RST;
      cfg_r.confirm_ms  <= CONFIRM_MS_RST;
      cfg_r.settle_ms   <= SETTLE_MS_RST;
      cfg_r.rebase_ms   <= REBASE_MS_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_DEADBAND_XY: cfg_r.deadband_xy <= cfg_data[15:0];
        REG_DEADBAND_Z:  cfg_r.deadband_z  <= cfg_data[15:0];
        REG_CONFIRM_MS:  cfg_r.confirm_ms  <= cfg_data;
        REG_SETTLE_MS:   cfg_r.settle_ms   <= cfg_data;
        REG_REBASE_MS:   cfg_r.rebase_ms   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
      res_vld_r  <= 1'b0;
      st_r       <= '0;
    end else begin
      if (in_valid && in_ready) begin
        item_vld_r <= 1'b1;
      end else if (advance) begin
        item_vld_r <= 1'b0;
      end
      if (advance) begin
        res_vld_r <= 1'b1;
        st_r      <= st_nxt;
      end else if (out_ready) begin
        res_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_data;
    end
    if (advance) begin
      res_r <= res_nxt;
    end
  end

endmodule

// ===== sv/amd_step.sv =====
module amd_step (
  input  amd_pkg::in_t    item,
  input  amd_pkg::cfg_t   cfg,
  input  amd_pkg::state_t st,
  output amd_pkg::state_t st_nxt,
  output amd_pkg::out_t   res
);
  import amd_pkg::*;

  logic               capture;
  logic               valid_now;
  logic signed [15:0] bx, by, bz;
  logic        [31:0] stamp_now;
  logic signed [16:0] dx, dy, dz;
  logic        [16:0] adx, ady, adz;
  logic               moving;
  logic        [31:0] since_dt, rebase_dt;
  logic               fire;

  always_comb begin
    capture   = !st.base_valid && (item.time_ms >= cfg.settle_ms);
    valid_now = st.base_valid || capture;
    bx        = capture ? item.accel_x : st.base_x;
    by        = capture ? item.accel_y : st.base_y;
    bz        = capture ? item.accel_z : st.base_z;
    stamp_now = capture ? item.time_ms : st.rebase_stamp;

    dx  = 17'(item.accel_x) - 17'(bx);
    dy  = 17'(item.accel_y) - 17'(by);
    dz  = 17'(item.accel_z) - 17'(bz);
    adx = dx[16] ? 17'(-dx) : 17'(dx);
    ady = dy[16] ? 17'(-dy) : 17'(dy);
    adz = dz[16] ? 17'(-dz) : 17'(dz);

    moving = valid_now &&
             ((adx > {1'b0, cfg.deadband_xy}) || (ady > {1'b0, cfg.deadband_xy}) ||
              (adz > {1'b0, cfg.deadband_z}));

    since_dt  = item.time_ms - st.motion_since;
    rebase_dt = item.time_ms - stamp_now;
    fire      = 1'b0;

    st_nxt = st;
    if (item.cmd == CMD_ACK) begin
      st_nxt.alert_latched = 1'b0;
    end else begin
      st_nxt.base_x       = bx;
      st_nxt.base_y       = by;
      st_nxt.base_z       = bz;
      st_nxt.base_valid   = valid_now;
      st_nxt.rebase_stamp = stamp_now;
      if (moving) begin
        // a start time of zero means not armed; arming never fires the alert
        if (st.motion_since == '0) begin
          st_nxt.motion_since = item.time_ms;
        end else if (since_dt >= cfg.confirm_ms && !st.alert_latched) begin
          st_nxt.alert_latched = 1'b1;
          fire                 = 1'b1;
        end
      end else if (valid_now) begin
        st_nxt.motion_since = '0;
        if (rebase_dt >= cfg.rebase_ms) begin
          st_nxt.base_x       = item.accel_x;
          st_nxt.base_y       = item.accel_y;
          st_nxt.base_z       = item.accel_z;
          st_nxt.rebase_stamp = item.time_ms;
        end
      end
    end

    res.recalib_event  = fire;
    res.alert          = st_nxt.alert_latched;
    res.moving         = (item.cmd == CMD_ACK) ? 1'b0 : moving;
    res.baseline_ready = st_nxt.base_valid;
  end

endmodule
